// ===== design/fctag_pkg.sv =====
// Shared types, constants and helper functions of the floor and ceiling texel address generator.
`default_nettype none

package fctag_pkg;

    localparam int ROW_W      = 9;
    localparam int COL_W      = 10;
    localparam int TEX_W      = 6;
    localparam int POS_W      = 28;
    localparam int DIR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam int SCREEN_HEIGHT = 480;
    localparam int HALF_H        = SCREEN_HEIGHT / 2;

    // Texel coordinate is the top TEX_W bits of the 16-bit fraction.
    localparam int TEX_SHIFT = 16 - TEX_W;

    // Row distance numerator, (SCREEN_HEIGHT/2) in Q16.16, and its saturated value.
    localparam logic [31:0] RD_NUM = 32'(HALF_H * 65536);
    localparam logic [31:0] RD_SAT = 32'hFFFF_FFFF;

    // The step divisor SCREEN_WIDTH * 2^14 equals 5 * 2^STEP_SHIFT. The division by 5 is a
    // multiply by ceil(2^30 / 5) and a shift by 30, exact for dividends below 2^30.
    localparam int          STEP_SHIFT       = 21;
    localparam logic [27:0] STEP_RECIP       = 28'd214748365;
    localparam int          STEP_RECIP_SHIFT = 30;

    // Ray offsets drop the 14 fraction bits of the direction.
    localparam int DIR_FRAC = 14;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DIR_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DIR_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DIR_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DIR_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLICKER_ON  = 3'd6;

    typedef enum logic [1:0] {
        TERM_STEP_X,
        TERM_STEP_Y,
        TERM_WORLD_X,
        TERM_WORLD_Y
    } t_term;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LOAD,
        S_RD_DIV,
        S_RD_STORE,
        S_MUL,
        S_ABS,
        S_DIV_LOAD,
        S_STORE,
        S_PIXEL
    } t_state;

    typedef struct packed {
        logic  take_direct;
        logic  take_latched;
        logic  latch_in;
        logic  load_rd_div;
        logic  load_step_div;
        logic  div_step;
        logic  store_rd;
        logic  mul;
        logic  mag;
        logic  store_term;
        t_term term;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic col_zero;
    } t_dp_status;

    function automatic logic [TEX_W-1:0] texel_of(input logic [31:0] w);
        logic [15:0] neg;
        logic [TEX_W-1:0] t;
        neg = 16'(-w[15:0]);
        if (!w[31]) begin
            t = w[15:TEX_SHIFT];
        end else begin
            t = TEX_W'(-neg[15:TEX_SHIFT]);
        end
        return t;
    endfunction

    // Parity of the integer part truncated toward zero.
    function automatic logic int_odd(input logic [31:0] w);
        return w[16] ^ (w[31] && (w[15:0] != 16'd0));
    endfunction

endpackage

`default_nettype wire

// ===== design/fctag_ctrl.sv =====
// Controller state machine that sequences row set-up and pixel output.
`default_nettype none

module fctag_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  fctag_pkg::t_dp_status  i_status,
    output fctag_pkg::t_dp_cmd     o_cmd
);
    import fctag_pkg::*;

    t_state                 r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    t_term                  r_term, n_term;
    logic                   w_accept;

    assign w_accept = (r_state == S_IDLE) && i_status.out_free && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_term  <= TERM_STEP_X;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_term  <= n_term;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_term  = r_term;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_status.col_zero) begin
                    n_state = S_RD_LOAD;
                end
            end
            S_RD_LOAD: begin
                n_cnt   = '0;
                n_state = S_RD_DIV;
            end
            S_RD_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_RD_STORE;
                end
            end
            S_RD_STORE: begin
                n_term  = TERM_STEP_X;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ABS;
            end
            S_ABS: begin
                if (r_term == TERM_STEP_X || r_term == TERM_STEP_Y) begin
                    n_state = S_DIV_LOAD;
                end else begin
                    n_state = S_STORE;
                end
            end
            S_DIV_LOAD: begin
                n_state = S_STORE;
            end
            S_STORE: begin
                if (r_term == TERM_WORLD_Y) begin
                    n_state = S_PIXEL;
                end else begin
                    n_term  = t_term'(r_term + 2'd1);
                    n_state = S_MUL;
                end
            end
            S_PIXEL: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready          = (r_state == S_IDLE) && i_status.out_free;
        o_cmd               = '0;
        o_cmd.term          = r_term;
        o_cmd.latch_in      = w_accept;
        o_cmd.take_direct   = w_accept && !i_status.col_zero;
        o_cmd.take_latched  = (r_state == S_PIXEL) && i_status.out_free;
        o_cmd.load_rd_div   = (r_state == S_RD_LOAD);
        o_cmd.div_step      = (r_state == S_RD_DIV);
        o_cmd.store_rd      = (r_state == S_RD_STORE);
        o_cmd.mul           = (r_state == S_MUL);
        o_cmd.mag           = (r_state == S_ABS);
        o_cmd.load_step_div = (r_state == S_DIV_LOAD);
        o_cmd.store_term    = (r_state == S_STORE);
    end

endmodule

`default_nettype wire

// ===== design/fctag_datapath.sv =====
// Datapath with configuration registers, divider, multipliers, world state and output register.
`default_nettype none

module fctag_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fctag_pkg::t_dp_cmd                i_cmd,
    output fctag_pkg::t_dp_status             o_status,
    input  logic [23:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,
    output logic [0:0]                        m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fctag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fctag_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fctag_pkg::*;

    logic [POS_W-1:0]        r_player_x, r_player_y;
    logic [DIR_W-1:0]        r_ldx, r_ldy, r_rdx, r_rdy;
    logic                    r_flicker;

    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic [31:0]             r_rd;
    logic                    r_sat;
    logic [8:0]              r_rem, r_dvs;
    logic [31:0]             r_quo;
    logic signed [49:0]      r_prod;
    logic [48:0]             r_mag;
    logic                    r_neg;
    logic [31:0]             r_world_x, r_world_y, r_step_x, r_step_y;

    logic [ROW_W-1:0]        r_o_floor_row, r_o_ceiling_row;
    logic [COL_W-1:0]        r_o_column;
    logic [TEX_W-1:0]        r_o_u, r_o_v;
    logic                    r_o_sel;
    logic                    r_o_valid;

    logic [ROW_W-1:0]        w_in_row, w_pix_row;
    logic [COL_W-1:0]        w_in_col, w_pix_col;
    logic [ROW_W:0]          w_p;
    logic [9:0]              w_trial;
    logic                    w_ge;
    logic [55:0]             w_step_prod;
    logic signed [32:0]      w_mul_a;
    logic signed [16:0]      w_mul_b;
    logic [31:0]             w_mag14, w_term_val;
    logic [31:0]             w_next_wx, w_next_wy;
    logic                    w_pixel;

    assign w_in_row = s_axis_tdata[ROW_W-1:0];
    assign w_in_col = s_axis_tdata[ROW_W +: COL_W];

    assign o_cfg_ready       = 1'b1;
    assign o_status.out_free = !r_o_valid || m_axis_tready;
    assign o_status.col_zero = (w_in_col == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= '0;
            r_player_y <= '0;
            r_ldx      <= '0;
            r_ldy      <= '0;
            r_rdx      <= '0;
            r_rdy      <= '0;
            r_flicker  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PLAYER_X:    r_player_x <= i_cfg_data;
                CFG_PLAYER_Y:    r_player_y <= i_cfg_data;
                CFG_LEFT_DIR_X:  r_ldx      <= i_cfg_data[DIR_W-1:0];
                CFG_LEFT_DIR_Y:  r_ldy      <= i_cfg_data[DIR_W-1:0];
                CFG_RIGHT_DIR_X: r_rdx      <= i_cfg_data[DIR_W-1:0];
                CFG_RIGHT_DIR_Y: r_rdy      <= i_cfg_data[DIR_W-1:0];
                CFG_FLICKER_ON:  r_flicker  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_row <= w_in_row;
            r_col <= w_in_col;
        end
    end

    // Row offset from the horizon; rows at or above it saturate.
    assign w_p = {1'b0, r_row} - (ROW_W + 1)'(HALF_H);

    assign w_trial = {r_rem, r_quo[31]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    assign w_step_prod = r_mag[48:STEP_SHIFT] * STEP_RECIP;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rd_div) begin
            r_rem <= '0;
            r_quo <= RD_NUM;
            r_dvs <= w_p[8:0];
            r_sat <= (r_row <= ROW_W'(HALF_H));
        end else if (i_cmd.load_step_div) begin
            r_quo <= 32'(w_step_prod >> STEP_RECIP_SHIFT);
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? 9'(w_trial - {1'b0, r_dvs}) : w_trial[8:0];
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_rd) begin
            r_rd <= r_sat ? RD_SAT : r_quo;
        end
    end

    assign w_mul_a = {1'b0, r_rd};

    always_comb begin
        unique case (i_cmd.term)
            TERM_STEP_X:  w_mul_b = {r_rdx[DIR_W-1], r_rdx} - {r_ldx[DIR_W-1], r_ldx};
            TERM_STEP_Y:  w_mul_b = {r_rdy[DIR_W-1], r_rdy} - {r_ldy[DIR_W-1], r_ldy};
            TERM_WORLD_X: w_mul_b = {r_ldx[DIR_W-1], r_ldx};
            TERM_WORLD_Y: w_mul_b = {r_ldy[DIR_W-1], r_ldy};
            default:      w_mul_b = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (i_cmd.mag) begin
            r_neg <= r_prod[49];
            r_mag <= r_prod[49] ? 49'(-r_prod) : r_prod[48:0];
        end
    end

    assign w_mag14 = r_mag[DIR_FRAC +: 32];

    always_comb begin
        unique case (i_cmd.term)
            TERM_STEP_X, TERM_STEP_Y: begin
                w_term_val = r_neg ? 32'(-r_quo) : r_quo;
            end
            TERM_WORLD_X: begin
                w_term_val = {4'd0, r_player_x} + (r_neg ? 32'(-w_mag14) : w_mag14);
            end
            TERM_WORLD_Y: begin
                w_term_val = {4'd0, r_player_y} + (r_neg ? 32'(-w_mag14) : w_mag14);
            end
            default: begin
                w_term_val = '0;
            end
        endcase
    end

    assign w_pixel   = i_cmd.take_direct || i_cmd.take_latched;
    assign w_pix_row = i_cmd.take_latched ? r_row : w_in_row;
    assign w_pix_col = i_cmd.take_latched ? r_col : w_in_col;
    assign w_next_wx = r_world_x + r_step_x;
    assign w_next_wy = r_world_y + r_step_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_x <= '0;
            r_world_y <= '0;
            r_step_x  <= '0;
            r_step_y  <= '0;
        end else if (i_cmd.store_term) begin
            unique case (i_cmd.term)
                TERM_STEP_X:  r_step_x  <= w_term_val;
                TERM_STEP_Y:  r_step_y  <= w_term_val;
                TERM_WORLD_X: r_world_x <= w_term_val;
                TERM_WORLD_Y: r_world_y <= w_term_val;
                default: begin
                end
            endcase
        end else if (w_pixel) begin
            r_world_x <= w_next_wx;
            r_world_y <= w_next_wy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pixel) begin
            r_o_floor_row   <= w_pix_row;
            r_o_ceiling_row <= ROW_W'(SCREEN_HEIGHT - 1) - w_pix_row;
            r_o_column      <= w_pix_col;
            r_o_u           <= texel_of(r_world_x);
            r_o_v           <= texel_of(r_world_y);
            r_o_sel         <= int_odd(w_next_wx) && int_odd(w_next_wy) && !r_flicker;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_pixel) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = {r_o_v, r_o_u, r_o_column, r_o_ceiling_row, r_o_floor_row};
    assign m_axis_tuser[0] = r_o_sel;

endmodule

`default_nettype wire

// ===== design/floor_ceiling_texel_address_gen_unit.sv =====
// Top level of the floor and ceiling texel address generator.
// A pixel with a nonzero column has its result registered at the edge that accepts it.
// Such pixels stream at one per clock while the output is taken.
// A pixel with column zero runs the row set-up first: the 32-step serial division for the row distance,
// then a multiply, magnitude and store for each step and world term, before its result is registered.
// Reset is synchronous and active low; it clears configuration, world state, controller state and output valid.
`default_nettype none

module floor_ceiling_texel_address_gen_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // row_y, col_x, zero fill
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,  // floor_row, ceiling_row, column,
                                                             // texel_u, texel_v
    output logic [0:0]                        m_axis_tuser,  // ceiling_select
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fctag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fctag_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fctag_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    fctag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fctag_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("input ready while the output register is blocked");

    a_pixel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[18:9] != 10'd0) |=> m_axis_tvalid)
        else $error("pixel item did not produce a result in the next cycle");

    a_pixel_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[18:9] != 10'd0)
        |=> (m_axis_tdata[8:0] == $past(s_axis_tdata[8:0])))
        else $error("result row does not match the accepted item");

    a_setup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[18:9] == 10'd0) |=> !s_axis_tready)
        else $error("new item accepted during row set-up");

endmodule

`default_nettype wire

// ===== verif/tb_floor_ceiling_texel_address_gen_unit.sv =====
// Self-checking testbench for the floor and ceiling texel address generator, with its own predictor.
`default_nettype none

module tb_floor_ceiling_texel_address_gen_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fctag_pkg::*;

    localparam int SCREEN_W         = 640;
    localparam int TEX_SIZE         = 64;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int PHASE_PIXELS     = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [ROW_W-1:0] floor_row;
        logic [ROW_W-1:0] ceiling_row;
        logic [COL_W-1:0] column;
        logic [TEX_W-1:0] texel_u;
        logic [TEX_W-1:0] texel_v;
        logic             ceiling_select;
    } t_pixel_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    floor_ceiling_texel_address_gen_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor copy of the registers and of the walking world position.
    logic [POS_W-1:0]        view_px, view_py;
    logic signed [DIR_W-1:0] view_lx, view_ly, view_rx, view_ry;
    logic                    view_flicker;
    logic [31:0]             pos_x, pos_y, stride_x, stride_y;

    t_pixel_result pending_pixels[$];
    int            mismatches = 0;
    bit            gapless = 1'b0;
    logic          sink_hold_req = 1'b0;
    int            sink_hold_left = 0;

    initial begin
        view_px = '0; view_py = '0;
        view_lx = '0; view_ly = '0; view_rx = '0; view_ry = '0;
        view_flicker = 1'b0;
        pos_x = '0; pos_y = '0; stride_x = '0; stride_y = '0;
    end

    function automatic logic [TEX_W-1:0] fraction_texel(input logic [31:0] w);
        longint s, whole, frac, t;
        s     = longint'($signed(w));
        whole = s / 65536;
        frac  = s - whole * 65536;
        t     = (TEX_SIZE * frac) / 65536;
        return t[TEX_W-1:0];
    endfunction

    function automatic bit whole_part_odd(input logic [31:0] w);
        longint s;
        s = longint'($signed(w));
        return ((s / 65536) % 2) != 0;
    endfunction

    function automatic void set_up_row(input logic [ROW_W-1:0] row);
        longint p, row_dist, lx, ly, rx, ry, span_div;
        p = longint'(row) - HALF_H;
        if (p <= 0) begin
            row_dist = 64'h0000_0000_FFFF_FFFF;
        end else begin
            row_dist = (longint'(HALF_H) * 65536) / p;
        end
        lx = view_lx; ly = view_ly; rx = view_rx; ry = view_ry;
        span_div = longint'(SCREEN_W) * 16384;
        stride_x = 32'((row_dist * (rx - lx)) / span_div);
        stride_y = 32'((row_dist * (ry - ly)) / span_div);
        pos_x    = 32'(longint'(view_px) + (row_dist * lx) / 16384);
        pos_y    = 32'(longint'(view_py) + (row_dist * ly) / 16384);
    endfunction

    function automatic t_pixel_result compute_pixel(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        t_pixel_result r;
        if (col == '0) begin
            set_up_row(row);
        end
        r.floor_row   = row;
        r.ceiling_row = ROW_W'(SCREEN_HEIGHT - int'(row) - 1);
        r.column      = col;
        r.texel_u     = fraction_texel(pos_x);
        r.texel_v     = fraction_texel(pos_y);
        pos_x = pos_x + stride_x;
        pos_y = pos_y + stride_y;
        r.ceiling_select = whole_part_odd(pos_x) && whole_part_odd(pos_y) && !view_flicker;
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_pixel(input logic [39:0] data, input logic [0:0] user);
        t_pixel_result want;
        if (pending_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: result with no item pending, expected none, actual 0x%h/%0d",
                     $time, data, user);
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("floor_row", want.floor_row, data[8:0]);
        compare_field("ceiling_row", want.ceiling_row, data[17:9]);
        compare_field("column", want.column, data[27:18]);
        compare_field("texel_u", want.texel_u, data[33:28]);
        compare_field("texel_v", want.texel_v, data[39:34]);
        compare_field("ceiling_select", want.ceiling_select, user[0]);
    endfunction

    // Output side: checks each item and drives tready, with random gaps and a long hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_pixel(m_axis_tdata, m_axis_tuser);
        end
        if (sink_hold_left > 0) begin
            sink_hold_left <= sink_hold_left - 1;
        end else if (sink_hold_req) begin
            sink_hold_left <= SINK_HOLD_CYCLES;
        end
        m_axis_tready <= (sink_hold_left <= 1) && !(sink_hold_left == 0 && sink_hold_req)
                         && (gapless || $urandom_range(99) >= 13);
    end

    task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        while (!gapless && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_pixels.push_back(compute_pixel(row, col));
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PLAYER_X:    view_px = val;
            CFG_PLAYER_Y:    view_py = val;
            CFG_LEFT_DIR_X:  view_lx = val[DIR_W-1:0];
            CFG_LEFT_DIR_Y:  view_ly = val[DIR_W-1:0];
            CFG_RIGHT_DIR_X: view_rx = val[DIR_W-1:0];
            CFG_RIGHT_DIR_Y: view_ry = val[DIR_W-1:0];
            CFG_FLICKER_ON:  view_flicker = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_view(input logic [CFG_DATA_W-1:0] px, py, lx, ly, rx, ry, fl);
        wait_results_done();
        write_reg(CFG_PLAYER_X, px);
        write_reg(CFG_PLAYER_Y, py);
        write_reg(CFG_LEFT_DIR_X, lx);
        write_reg(CFG_LEFT_DIR_Y, ly);
        write_reg(CFG_RIGHT_DIR_X, rx);
        write_reg(CFG_RIGHT_DIR_Y, ry);
        write_reg(CFG_FLICKER_ON, fl);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_position();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_direction();
        logic [11:0] junk;
        junk = 12'($urandom);
        case ($urandom_range(9))
            0:       return {junk, 16'h8000};
            1:       return {junk, 16'h7FFF};
            2:       return {junk, 16'h0000};
            3:       return {junk, 16'(int'($urandom_range(8191)) - 4096)};
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic randomize_view();
        set_view(pick_position(), pick_position(), pick_direction(), pick_direction(),
                 pick_direction(), pick_direction(), CFG_DATA_W'($urandom_range(99) < 25));
    endtask

    // Mostly runs along a row starting at column zero; the rest are stray pixels.
    task automatic send_frame_pixels(input int total);
        int sent;
        int run;
        logic [ROW_W-1:0] row;
        sent = 0;
        while (sent < total) begin
            if ($urandom_range(99) < 10) begin
                send_pixel(ROW_W'($urandom_range(511)), COL_W'($urandom_range(1023)));
                sent++;
            end else begin
                row = ($urandom_range(99) < 85) ? ROW_W'($urandom_range(479, 241))
                                                : ROW_W'($urandom_range(511));
                run = ($urandom_range(99) < 5) ? $urandom_range(120, 60) : $urandom_range(40, 1);
                for (int c = 0; c < run; c++) begin
                    send_pixel(row, COL_W'(c));
                end
                sent += run;
            end
        end
    endtask

    task automatic test_no_setup();
        send_pixel(9'd300, 10'd5);
        send_pixel(9'd479, 10'd1023);
        send_pixel(9'd0, 10'd1);
    endtask

    task automatic test_horizon();
        set_view(28'h0123456, 28'h0ABCDEF, 28'h0002000, 28'h000C000, 28'h0003000, 28'h0001000,
                 28'd0);
        send_pixel(9'd240, 10'd0);
        send_pixel(9'd240, 10'd1);
        send_pixel(9'd0, 10'd0);
        send_pixel(9'd239, 10'd0);
        send_pixel(9'd239, 10'd2);
    endtask

    task automatic test_off_screen();
        send_pixel(9'd241, 10'd0);
        send_pixel(9'd241, 10'd1);
        send_pixel(9'd479, 10'd0);
        send_pixel(9'd480, 10'd0);
        send_pixel(9'd480, 10'd640);
        send_pixel(9'd511, 10'd0);
        send_pixel(9'd511, 10'd1023);
    endtask

    task automatic test_extreme_config();
        set_view(28'hFFFFFFF, 28'hFFFFFFF, 28'hFFF8000, 28'hFFF8000, 28'h0007FFF, 28'h0007FFF,
                 28'd0);
        send_pixel(9'd241, 10'd0);
        send_pixel(9'd241, 10'd1);
        send_pixel(9'd241, 10'd639);
        set_view(28'd0, 28'd0, 28'h0007FFF, 28'h0008000, 28'h0008000, 28'h0007FFF, 28'd0);
        send_pixel(9'd300, 10'd0);
        send_pixel(9'd300, 10'd1);
    endtask

    task automatic test_flicker();
        set_view(28'h0018000, 28'h0038000, 28'd0, 28'd0, 28'd0, 28'd0, 28'd0);
        send_pixel(9'd300, 10'd0);
        send_pixel(9'd300, 10'd1);
        wait_results_done();
        write_reg(CFG_FLICKER_ON, 28'd1);
        send_pixel(9'd300, 10'd2);
        wait_results_done();
        write_reg(CFG_FLICKER_ON, 28'd0);
    endtask

    task automatic test_ignored_index();
        wait_results_done();
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        send_pixel(9'd350, 10'd0);
        send_pixel(9'd350, 10'd1);
    endtask

    task automatic test_backpressure();
        randomize_view();
        sink_hold_req <= 1'b1;
        do @(posedge i_clk); while (sink_hold_left == 0);
        sink_hold_req <= 1'b0;
        send_frame_pixels(60);
        wait_results_done();
    endtask

    task automatic test_random_frames();
        for (int phase = 0; phase < 6; phase++) begin
            randomize_view();
            gapless = (phase == 2);
            send_frame_pixels(PHASE_PIXELS);
        end
        gapless = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_no_setup();
        test_horizon();
        test_off_screen();
        test_extreme_config();
        test_flicker();
        test_ignored_index();
        test_backpressure();
        test_random_frames();
        wait_results_done();
        repeat (150) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
